// File: rtl/core/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Types, token kind codes and character helpers for the expression scanner.
// ----------------------------------------------------------------------------
package ets_pkg;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] length;
    logic [7:0] other_byte;
    logic       last;
  } out_item_t;

  // scan modes, one-hot
  typedef enum logic [8:0] {
    MODE_IDLE       = 9'b000000001,
    MODE_INT        = 9'b000000010,
    MODE_FRAC_START = 9'b000000100,
    MODE_FRAC       = 9'b000001000,
    MODE_EXP_START  = 9'b000010000,
    MODE_EXP_SIGN   = 9'b000100000,
    MODE_EXP        = 9'b001000000,
    MODE_IDENT      = 9'b010000000,
    MODE_TEXT       = 9'b100000000
  } scan_mode_t;

  localparam logic [3:0] KIND_NUMBER   = 4'd0;
  localparam logic [3:0] KIND_IDENT    = 4'd1;
  localparam logic [3:0] KIND_FUNCTION = 4'd2;
  localparam logic [3:0] KIND_TRUE     = 4'd3;
  localparam logic [3:0] KIND_TEXT     = 4'd8;
  localparam logic [3:0] KIND_ERROR    = 4'd9;
  localparam logic [3:0] KIND_OTHER    = 4'd10;

  localparam int unsigned NUM_KW = 5;

  localparam logic [7:0] CH_LPAREN = 8'h28;  // (
  localparam logic [7:0] CH_DOT    = 8'h2E;  // .
  localparam logic [7:0] CH_QUOTE  = 8'h22;  // "
  localparam logic [7:0] CH_E_LO   = 8'h65;  // e
  localparam logic [7:0] CH_E_UP   = 8'h45;  // E
  localparam logic [7:0] CH_PLUS   = 8'h2B;  // +
  localparam logic [7:0] CH_MINUS  = 8'h2D;  // -

  function automatic logic is_digit(input logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_letter(input logic [7:0] b);
    return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

  // keyword lengths: true, false, and, not, or
  function automatic logic [2:0] kw_len(input logic [2:0] k);
    logic [2:0] len;
    case (k)
      3'd0:    len = 3'd4;
      3'd1:    len = 3'd5;
      3'd2:    len = 3'd3;
      3'd3:    len = 3'd3;
      3'd4:    len = 3'd2;
      default: len = 3'd0;
    endcase
    return len;
  endfunction

  function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] pos);
    logic [7:0] c;
    c = 8'h00;
    case (k)
      3'd0: case (pos)
              3'd0: c = "t"; 3'd1: c = "r"; 3'd2: c = "u"; 3'd3: c = "e";
              default: c = 8'h00;
            endcase
      3'd1: case (pos)
              3'd0: c = "f"; 3'd1: c = "a"; 3'd2: c = "l"; 3'd3: c = "s";
              3'd4: c = "e";
              default: c = 8'h00;
            endcase
      3'd2: case (pos)
              3'd0: c = "a"; 3'd1: c = "n"; 3'd2: c = "d";
              default: c = 8'h00;
            endcase
      3'd3: case (pos)
              3'd0: c = "n"; 3'd1: c = "o"; 3'd2: c = "t";
              default: c = 8'h00;
            endcase
      3'd4: case (pos)
              3'd0: c = "o"; 3'd1: c = "r";
              default: c = 8'h00;
            endcase
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/core/expression_token_scanner.sv
// ----------------------------------------------------------------------------
// expression_token_scanner
// Byte-at-a-time lexer for numbers, identifiers, keywords, functions and text.
// ----------------------------------------------------------------------------
// One source byte is accepted per cycle. The scan state is updated in the same
// cycle the byte is taken, and the zero, one or two tokens it completes are
// written into a four-entry result queue, which gives the first result in the
// cycle after the byte. in_ready drops only when the queue holds three or more
// results, so with a result taken every cycle the scanner runs at one byte per
// clock; bytes that close a token and also produce an 'other' token emit two
// results and can slow the stream only if the output side cannot drain them.
module expression_token_scanner
  import ets_pkg::*;
#(
  parameter int unsigned LENGTH_BITS = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

  // scan state
  scan_mode_t             scan_mode, scan_mode_next;
  logic [LENGTH_BITS-1:0] token_length, token_length_next;
  logic [NUM_KW-1:0]      keyword_alive, keyword_alive_next;
  logic                   length_overflow, length_overflow_next;

  // result queue
  out_item_t  fifo [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  logic       in_fire, out_fire;
  logic [1:0] nres;
  out_item_t  res0, res1;

  function automatic logic [7:0] shown_of(input logic [LENGTH_BITS-1:0] len,
                                          input logic ovf);
    if (ovf || (32'(len) > 32'd255))
      return 8'hFF;
    return 8'(len);
  endfunction

  // per-byte precomputed terms
  logic [7:0]             b;
  logic                   dig, let_b, is_e;
  logic [LENGTH_BITS-1:0] grow_len;
  logic                   grow_ovf;
  logic [NUM_KW-1:0]      kw_upd, kw_first;
  logic [3:0]             id_kind;
  logic [7:0]             shown, shown_grown;
  scan_mode_t             idle_mode;
  logic                   idle_other;
  logic [NUM_KW-1:0]      idle_alive;

  always_comb begin
    b     = in_data.byte_in;
    dig   = is_digit(b);
    let_b = is_letter(b);
    is_e  = (b == CH_E_LO) || (b == CH_E_UP);

    if (token_length == LEN_MAX) begin
      grow_len = token_length;
      grow_ovf = 1'b1;
    end else begin
      grow_len = token_length + LENGTH_BITS'(1);
      grow_ovf = length_overflow;
    end

    shown       = shown_of(token_length, length_overflow);
    shown_grown = shown_of(grow_len, grow_ovf);

    for (int k = 0; k < NUM_KW; k++) begin
      kw_upd[k] = keyword_alive[k];
      if ((token_length >= LENGTH_BITS'(kw_len(3'(k)))) ||
          (kw_char(3'(k), token_length[2:0]) != b))
        kw_upd[k] = 1'b0;
      kw_first[k] = (kw_char(3'(k), 3'd0) == b);
    end

    // first live keyword whose length matches wins
    id_kind = KIND_IDENT;
    if (!length_overflow) begin
      for (int k = NUM_KW - 1; k >= 0; k--) begin
        if (keyword_alive[k] && (token_length == LENGTH_BITS'(kw_len(3'(k)))))
          id_kind = KIND_TRUE + 4'(k);
      end
    end

    // byte handled from idle
    idle_other = 1'b0;
    idle_alive = '1;
    if (dig) begin
      idle_mode = MODE_INT;
    end else if (let_b) begin
      idle_mode  = MODE_IDENT;
      idle_alive = kw_first;
    end else if (b == CH_QUOTE) begin
      idle_mode = MODE_TEXT;
    end else begin
      idle_mode  = MODE_IDLE;
      idle_other = 1'b1;
    end
  end

  always_comb begin
    logic end_tok;
    logic [3:0] end_kind;

    scan_mode_next       = scan_mode;
    token_length_next    = token_length;
    keyword_alive_next   = keyword_alive;
    length_overflow_next = length_overflow;
    nres     = 2'd0;
    res0     = '0;
    res1     = '0;
    end_tok  = 1'b0;
    end_kind = KIND_NUMBER;

    if (in_data.end_of_input) begin
      scan_mode_next       = MODE_IDLE;
      token_length_next    = '0;
      keyword_alive_next   = '1;
      length_overflow_next = 1'b0;
      res0.length = shown;
      unique case (scan_mode)
        MODE_INT, MODE_FRAC, MODE_EXP: begin
          res0.kind = KIND_NUMBER;
          nres      = 2'd1;
        end
        MODE_FRAC_START, MODE_EXP_START, MODE_EXP_SIGN, MODE_TEXT: begin
          res0.kind = KIND_ERROR;
          nres      = 2'd1;
        end
        MODE_IDENT: begin
          res0.kind = id_kind;
          nres      = 2'd1;
        end
        default: nres = 2'd0;
      endcase
    end else begin
      unique case (scan_mode)
        MODE_INT, MODE_FRAC: begin
          if (dig || (b == CH_DOT && scan_mode == MODE_INT) || is_e) begin
            token_length_next    = grow_len;
            length_overflow_next = grow_ovf;
            if (is_e)
              scan_mode_next = MODE_EXP_START;
            else if (!dig)
              scan_mode_next = MODE_FRAC_START;
          end else begin
            end_tok  = 1'b1;
            end_kind = KIND_NUMBER;
          end
        end
        MODE_FRAC_START, MODE_EXP_SIGN: begin
          if (dig) begin
            token_length_next    = grow_len;
            length_overflow_next = grow_ovf;
            scan_mode_next = (scan_mode == MODE_FRAC_START) ? MODE_FRAC : MODE_EXP;
          end else begin
            end_tok  = 1'b1;
            end_kind = KIND_ERROR;
          end
        end
        MODE_EXP_START: begin
          if (dig || b == CH_PLUS || b == CH_MINUS) begin
            token_length_next    = grow_len;
            length_overflow_next = grow_ovf;
            scan_mode_next = dig ? MODE_EXP : MODE_EXP_SIGN;
          end else begin
            end_tok  = 1'b1;
            end_kind = KIND_ERROR;
          end
        end
        MODE_EXP: begin
          if (dig) begin
            token_length_next    = grow_len;
            length_overflow_next = grow_ovf;
          end else begin
            end_tok  = 1'b1;
            end_kind = KIND_NUMBER;
          end
        end
        MODE_IDENT: begin
          if (dig || let_b) begin
            keyword_alive_next   = kw_upd;
            token_length_next    = grow_len;
            length_overflow_next = grow_ovf;
          end else if (id_kind == KIND_IDENT && b == CH_LPAREN) begin
            // '(' is part of the function token
            res0.kind            = KIND_FUNCTION;
            res0.length          = shown_grown;
            nres                 = 2'd1;
            scan_mode_next       = MODE_IDLE;
            token_length_next    = '0;
            keyword_alive_next   = '1;
            length_overflow_next = 1'b0;
          end else begin
            end_tok  = 1'b1;
            end_kind = id_kind;
          end
        end
        MODE_TEXT: begin
          token_length_next    = grow_len;
          length_overflow_next = grow_ovf;
          if (b == CH_QUOTE) begin
            res0.kind            = KIND_TEXT;
            res0.length          = shown_grown;
            nres                 = 2'd1;
            scan_mode_next       = MODE_IDLE;
            token_length_next    = '0;
            keyword_alive_next   = '1;
            length_overflow_next = 1'b0;
          end
        end
        default: begin
          // idle: byte starts a token or passes out as other
          scan_mode_next       = idle_mode;
          keyword_alive_next   = idle_alive;
          length_overflow_next = 1'b0;
          token_length_next    = idle_other ? '0 : LENGTH_BITS'(1);
          if (idle_other) begin
            res0.kind       = KIND_OTHER;
            res0.length     = 8'd1;
            res0.other_byte = b;
            nres            = 2'd1;
          end
        end
      endcase

      if (end_tok) begin
        res0.kind            = end_kind;
        res0.length          = shown;
        scan_mode_next       = idle_mode;
        keyword_alive_next   = idle_alive;
        length_overflow_next = 1'b0;
        token_length_next    = idle_other ? '0 : LENGTH_BITS'(1);
        if (idle_other) begin
          res1.kind       = KIND_OTHER;
          res1.length     = 8'd1;
          res1.other_byte = b;
          nres            = 2'd2;
        end else begin
          nres = 2'd1;
        end
      end
    end

    res0.last = (nres == 2'd1);
    res1.last = 1'b1;
  end

  assign in_ready  = (count <= 3'd2);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (count != 3'd0);
  assign out_fire  = out_valid && out_ready;
  assign out_data  = fifo[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode       <= MODE_IDLE;
      token_length    <= '0;
      keyword_alive   <= '1;
      length_overflow <= 1'b0;
      wr_ptr          <= '0;
      rd_ptr          <= '0;
      count           <= '0;
    end else begin
      if (in_fire) begin
        scan_mode       <= scan_mode_next;
        token_length    <= token_length_next;
        keyword_alive   <= keyword_alive_next;
        length_overflow <= length_overflow_next;
        wr_ptr          <= wr_ptr + 2'(in_fire ? nres : 2'd0);
      end
      if (out_fire)
        rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(in_fire ? nres : 2'd0) - 3'(out_fire);
    end
  end

  // queue payload, no reset
  always_ff @(posedge clk) begin
    if (in_fire && nres != 2'd0)
      fifo[wr_ptr] <= res0;
    if (in_fire && nres == 2'd2)
      fifo[wr_ptr + 2'd1] <= res1;
  end

endmodule

// File: tb/expression_token_scanner_checker.sv
// ----------------------------------------------------------------------------
// expression_token_scanner_checker
// Watches both item channels of the scanner, predicts the tokens every
// accepted byte completes and compares each delivered token in order.
// ----------------------------------------------------------------------------
module expression_token_scanner_checker
  import ets_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_item_t    in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_item_t   out_data,
  output int          fail_count,
  output int          pending,
  output int          token_count,
  output logic [10:0] kinds_seen
);

  scan_mode_t  mode;
  logic [7:0]  tok_len;
  logic [4:0]  alive;
  logic        overflow;

  out_item_t   expected_tokens[$];
  out_item_t   staged[2];
  int          staged_n;

  initial begin
    fail_count  = 0;
    pending     = 0;
    token_count = 0;
    kinds_seen  = '0;
  end

  // keyword spellings, right aligned: true, false, and, not, or
  function automatic logic [39:0] kw_spelling(input int k);
    case (k)
      0:       return "true";
      1:       return "false";
      2:       return "and";
      3:       return "not";
      default: return "or";
    endcase
  endfunction

  function automatic int kw_size(input int k);
    case (k)
      0:       return 4;
      1:       return 5;
      2:       return 3;
      3:       return 3;
      default: return 2;
    endcase
  endfunction

  function automatic logic digit_byte(input logic [7:0] b);
    return (b >= "0") && (b <= "9");
  endfunction

  function automatic logic letter_byte(input logic [7:0] b);
    return ((b >= "a") && (b <= "z")) || ((b >= "A") && (b <= "Z"));
  endfunction

  function automatic logic [7:0] shown_len();
    return overflow ? 8'hFF : tok_len;
  endfunction

  function automatic logic [3:0] ident_kind();
    logic [3:0] kind;
    kind = KIND_IDENT;
    if (!overflow) begin
      for (int k = NUM_KW - 1; k >= 0; k--) begin
        if (alive[k] && int'(tok_len) == kw_size(k)) kind = KIND_TRUE + 4'(k);
      end
    end
    return kind;
  endfunction

  task automatic restart(input scan_mode_t m);
    mode     = m;
    tok_len  = '0;
    overflow = 1'b0;
    alive    = 5'h1F;
  endtask

  task automatic grow();
    if (tok_len == 8'hFF) overflow = 1'b1;
    else tok_len = tok_len + 8'd1;
  endtask

  // drop keywords that the byte at the current position rules out
  task automatic note_keyword(input logic [7:0] b);
    logic [39:0] spell;
    int          size;
    for (int k = 0; k < NUM_KW; k++) begin
      size  = kw_size(k);
      spell = kw_spelling(k);
      if (alive[k]) begin
        if (int'(tok_len) >= size) alive[k] = 1'b0;
        else if (spell[8*(size-1-int'(tok_len)) +: 8] != b) alive[k] = 1'b0;
      end
    end
  endtask

  task automatic emit(input logic [3:0] kind, input logic [7:0] len, input logic [7:0] ob);
    out_item_t t;
    t.kind       = kind;
    t.length     = len;
    t.other_byte = ob;
    t.last       = 1'b0;
    staged[staged_n] = t;
    staged_n++;
  endtask

  task automatic start_from_idle(input logic [7:0] b);
    if (digit_byte(b)) begin
      restart(MODE_INT);
      grow();
    end else if (letter_byte(b)) begin
      restart(MODE_IDENT);
      note_keyword(b);
      grow();
    end else if (b == CH_QUOTE) begin
      restart(MODE_TEXT);
      grow();
    end else begin
      restart(MODE_IDLE);
      emit(KIND_OTHER, 8'd1, b);
    end
  endtask

  // token closed by b, which is then scanned again from idle
  task automatic close_token(input logic [3:0] kind, input logic [7:0] b);
    emit(kind, shown_len(), 8'h00);
    start_from_idle(b);
  endtask

  task automatic advance_scanner(input in_item_t it);
    logic [7:0] b;
    logic [3:0] kind;
    b = it.byte_in;
    staged_n = 0;
    if (it.end_of_input) begin
      case (mode)
        MODE_INT, MODE_FRAC, MODE_EXP: emit(KIND_NUMBER, shown_len(), 8'h00);
        MODE_FRAC_START, MODE_EXP_START, MODE_EXP_SIGN, MODE_TEXT:
          emit(KIND_ERROR, shown_len(), 8'h00);
        MODE_IDENT: emit(ident_kind(), shown_len(), 8'h00);
        default: ;
      endcase
      restart(MODE_IDLE);
    end else begin
      case (mode)
        MODE_INT: begin
          if (digit_byte(b)) grow();
          else if (b == CH_DOT) begin
            grow();
            mode = MODE_FRAC_START;
          end else if (b == CH_E_LO || b == CH_E_UP) begin
            grow();
            mode = MODE_EXP_START;
          end else close_token(KIND_NUMBER, b);
        end
        MODE_FRAC_START: begin
          if (digit_byte(b)) begin
            grow();
            mode = MODE_FRAC;
          end else close_token(KIND_ERROR, b);
        end
        MODE_FRAC: begin
          if (digit_byte(b)) grow();
          else if (b == CH_E_LO || b == CH_E_UP) begin
            grow();
            mode = MODE_EXP_START;
          end else close_token(KIND_NUMBER, b);
        end
        MODE_EXP_START: begin
          if (b == CH_PLUS || b == CH_MINUS) begin
            grow();
            mode = MODE_EXP_SIGN;
          end else if (digit_byte(b)) begin
            grow();
            mode = MODE_EXP;
          end else close_token(KIND_ERROR, b);
        end
        MODE_EXP_SIGN: begin
          if (digit_byte(b)) begin
            grow();
            mode = MODE_EXP;
          end else close_token(KIND_ERROR, b);
        end
        MODE_EXP: begin
          if (digit_byte(b)) grow();
          else close_token(KIND_NUMBER, b);
        end
        MODE_IDENT: begin
          if (letter_byte(b) || digit_byte(b)) begin
            note_keyword(b);
            grow();
          end else begin
            kind = ident_kind();
            // a keyword never becomes a call; its '(' goes out as other
            if (kind == KIND_IDENT && b == CH_LPAREN) begin
              grow();
              emit(KIND_FUNCTION, shown_len(), 8'h00);
              restart(MODE_IDLE);
            end else close_token(kind, b);
          end
        end
        MODE_TEXT: begin
          grow();
          if (b == CH_QUOTE) begin
            emit(KIND_TEXT, shown_len(), 8'h00);
            restart(MODE_IDLE);
          end
        end
        default: start_from_idle(b);
      endcase
    end
    for (int i = 0; i < staged_n; i++) begin
      if (i == staged_n - 1) staged[i].last = 1'b1;
      expected_tokens.push_back(staged[i]);
    end
  endtask

  task automatic check_token(input out_item_t got);
    out_item_t want;
    token_count++;
    if (got.kind <= KIND_OTHER) kinds_seen[got.kind] = 1'b1;
    if (expected_tokens.size() == 0) begin
      if (fail_count < 10)
        $display("unexpected token: kind %0d len %0d byte %02h last %0d",
                 got.kind, got.length, got.other_byte, got.last);
      fail_count++;
    end else begin
      want = expected_tokens.pop_front();
      if (got.kind != want.kind || got.length != want.length ||
          got.other_byte != want.other_byte || got.last != want.last) begin
        if (fail_count < 10)
          $display("token mismatch: expected kind %0d len %0d byte %02h last %0d, got kind %0d len %0d byte %02h last %0d",
                   want.kind, want.length, want.other_byte, want.last,
                   got.kind, got.length, got.other_byte, got.last);
        fail_count++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      restart(MODE_IDLE);
      expected_tokens.delete();
      pending <= 0;
    end else begin
      if (in_valid && in_ready) advance_scanner(in_data);
      if (out_valid && out_ready) check_token(out_data);
      pending <= expected_tokens.size();
    end
  end

endmodule

// File: tb/tb_expression_token_scanner.sv
// ----------------------------------------------------------------------------
// tb_expression_token_scanner
// Feeds the scanner a directed byte sequence, long tokens and random token
// streams under several idle and stall mixes; the checker predicts and
// compares every token, and this top reports the verdict.
// ----------------------------------------------------------------------------
module tb_expression_token_scanner;
  import ets_pkg::*;

  localparam int CYCLE_LIMIT = 100000;
  localparam int PHASE_ITEMS = 165;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;

  int          fail_count;
  int          pending;
  int          token_count;
  logic [10:0] kinds_seen;

  int          idle_pct  = 0;
  int          stall_pct = 0;
  int          cycles    = 0;
  int          items_sent = 0;
  in_item_t    script[$];

  expression_token_scanner dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  expression_token_scanner_checker token_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .token_count (token_count),
    .kinds_seen  (kinds_seen)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) out_ready <= ($urandom_range(99) >= stall_pct);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("expression_token_scanner test failed");
      $finish;
    end
  end

  function automatic void put_byte(input logic [7:0] b);
    in_item_t it;
    it.byte_in      = b;
    it.end_of_input = 1'b0;
    script.push_back(it);
  endfunction

  // byte lane is don't-care on a flush, so it carries noise
  function automatic void put_eoi();
    in_item_t it;
    it.byte_in      = 8'($urandom_range(255));
    it.end_of_input = 1'b1;
    script.push_back(it);
  endfunction

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endfunction

  function automatic logic [7:0] rand_letter();
    return ($urandom_range(1) ? 8'h41 : 8'h61) + 8'($urandom_range(25));
  endfunction

  function automatic logic [7:0] rand_digit();
    return 8'h30 + 8'($urandom_range(9));
  endfunction

  function automatic string keyword_word(input int k);
    case (k)
      0:       return "true";
      1:       return "false";
      2:       return "and";
      3:       return "not";
      default: return "or";
    endcase
  endfunction

  function automatic logic [7:0] separator();
    string      seps;
    logic [7:0] b;
    seps = " ()+-*/,;<>=!";
    if ($urandom_range(1)) return seps[$urandom_range(seps.len() - 1)];
    do b = 8'($urandom_range(255));
    while ((b >= "0" && b <= "9") || (b >= "a" && b <= "z") ||
           (b >= "A" && b <= "Z") || b == CH_QUOTE);
    return b;
  endfunction

  // digits(.digits)?([eE][+-]?digits)?, sometimes missing the digits
  function automatic void add_number();
    repeat (1 + $urandom_range(3)) put_byte(rand_digit());
    if ($urandom_range(99) < 35) begin
      put_byte(CH_DOT);
      if ($urandom_range(99) < 85) repeat (1 + $urandom_range(2)) put_byte(rand_digit());
    end
    if ($urandom_range(99) < 30) begin
      put_byte($urandom_range(1) ? CH_E_LO : CH_E_UP);
      if ($urandom_range(1)) put_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
      if ($urandom_range(99) < 85) repeat (1 + $urandom_range(2)) put_byte(rand_digit());
    end
  endfunction

  function automatic void add_word();
    string kw;
    int    w;
    kw = keyword_word($urandom_range(NUM_KW - 1));
    w  = $urandom_range(99);
    if (w < 35) put_text(kw);
    else if (w < 45) begin
      for (int i = 0; i < kw.len() - 1; i++) put_byte(kw[i]);
    end else if (w < 55) begin
      put_text(kw);
      put_byte($urandom_range(1) ? rand_letter() : rand_digit());
    end else if (w < 62) begin
      // keywords are case sensitive
      for (int i = 0; i < kw.len(); i++) put_byte(kw[i] - 8'h20);
    end else begin
      put_byte(rand_letter());
      repeat ($urandom_range(5)) put_byte($urandom_range(2) == 0 ? rand_digit() : rand_letter());
    end
    if ($urandom_range(99) < 30) put_byte(CH_LPAREN);
  endfunction

  function automatic void add_quoted();
    logic [7:0] b;
    put_byte(CH_QUOTE);
    repeat ($urandom_range(6)) begin
      do b = 8'($urandom_range(255));
      while (b == CH_QUOTE);
      put_byte(b);
    end
    if ($urandom_range(99) < 88) put_byte(CH_QUOTE);
    else put_eoi();
  endfunction

  function automatic void add_random_token();
    int r;
    r = $urandom_range(99);
    if (r < 25) add_number();
    else if (r < 55) add_word();
    else if (r < 67) add_quoted();
    else if (r < 90) put_byte(separator());
    else if (r < 96) put_eoi();
    else repeat (1 + $urandom_range(3)) put_byte(8'($urandom_range(255)));
  endfunction

  // 256-byte name starting like a keyword, then '(' : count overflows
  function automatic void add_long_call();
    put_text("false");
    repeat (251) put_byte($urandom_range(3) == 0 ? rand_digit() : rand_letter());
    put_byte(CH_LPAREN);
  endfunction

  // text of exactly 255 bytes: count reaches the top without overflow
  function automatic void add_long_text();
    logic [7:0] b;
    put_byte(CH_QUOTE);
    repeat (253) begin
      do b = 8'($urandom_range(255));
      while (b == CH_QUOTE);
      put_byte(b);
    end
    put_byte(CH_QUOTE);
  endfunction

  task automatic send_item(input in_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk);
    while (!in_ready);
    items_sent++;
  endtask

  // send the queued bytes, then hold off until every token has come back
  task automatic run_script(input int idle, input int stall);
    idle_pct = idle;
    stall_pct <= stall;
    foreach (script[i]) send_item(script[i]);
    in_valid <= 1'b0;
    script.delete();
    do @(posedge clk);
    while (pending != 0);
  endtask

  initial begin
    int base;
    rst       <= 1'b1;
    in_valid  <= 1'b0;
    in_data   <= '0;
    out_ready <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    put_byte(8'h00);
    put_byte(8'hFF);
    put_text("true(");      // keyword, then '(' as other
    put_text("f1(");        // call
    put_text("2.5E+7;");    // full number form
    put_text("1.e");        // fraction without digits
    put_eoi();              // flushes the name "e"
    put_text("\"a\"");
    put_text("\"b");
    put_eoi();              // unterminated text
    put_eoi();              // flush while idle
    run_script(0, 0);

    for (int p = 0; p < 4; p++) begin
      if (p == 1) add_long_call();
      if (p == 2) add_long_text();
      base = script.size();
      while (script.size() < base + PHASE_ITEMS) add_random_token();
      case (p)
        0:       run_script(0, 0);
        1:       run_script(58, 0);
        2:       run_script(0, 58);
        default: run_script(28, 28);
      endcase
    end

    repeat (8) @(posedge clk);
    $display("sent %0d bytes across four idle/stall mixes, checked %0d tokens",
             items_sent, token_count);
    $display("token kinds seen (bit per kind): %b", kinds_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("expression_token_scanner test passed");
    end else begin
      $display("expression_token_scanner test failed");
    end
    $finish;
  end

endmodule
